FILE: rtl/assert_macros.svh
// Assertion macros included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also covers the reset cycles.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sitda_pkg.sv
// Package: types and constants for the integer to decimal text converter.
`timescale 1ns / 1ps

package sitda_pkg;

   // Default width of the signed input value
   localparam int VALUE_WIDTH_DEF = 32;

   // ASCII codes used in the output run
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/signed_int_to_decimal_ascii.sv
// Top level: signed integer to decimal ASCII character stream converter.
//
// Usage:
//   The req_ channel takes one signed two's complement value per request.
//   The rsp_ channel returns its decimal text one ASCII character per beat,
//   most significant first, with a leading '-' for negative values. Leading
//   zeros are dropped; zero gives a single '0'. rsp_tlast marks the final
//   character of each run. The most negative value converts exactly.
//   Timing: the magnitude is converted by a shift-add-3 (double dabble) loop,
//   one input bit per cycle. Leading zero digits are then dropped one per
//   cycle, keeping at least one of the ND digit slots (ND = 10 at 32 bits),
//   a final step ends that pass, and the characters leave one per cycle
//   while the receiver does not stall.
//   One request is worked at a time; req_tready is high only when the
//   sequencer is idle, which it may be while the final character still waits
//   in the output register.
//   Reset clears the sequencer and the output valid flag.
//   A receiver stall holds the current character and pauses the run.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_int_to_decimal_ascii
   import sitda_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,  // [VALUE_WIDTH-1:0] value
   // response channel
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [7:0]                             rsp_tdata,  // [7:0] character
   output logic                                   rsp_tlast   // last
);

   // Decimal digits needed for any VALUE_WIDTH-bit magnitude
   localparam int ND      = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int BW      = ND * 4;
   localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);
   localparam int DIG_W   = $clog2(ND + 1);

   state_type            state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BW-1:0]        bcd_ff, bcd_in;
   logic [BW-1:0]        bcd_adj;
   logic [CNT_W-1:0]     bits_ff, bits_in;
   logic [DIG_W-1:0]     dig_ff, dig_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [VALUE_WIDTH-1:0] raw_value;
   logic [3:0]           top_digit;
   logic                 slot_free;

   assign raw_value  = req_tdata[VALUE_WIDTH-1:0];
   assign top_digit  = bcd_ff[BW-1 -: 4];
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Add-3 correction on every BCD digit of five or more
   always_comb begin
      logic [3:0] dg;
      dg = '0;
      for (int i = 0; i < ND; i++) begin
         dg = bcd_ff[i*4 +: 4];
         bcd_adj[i*4 +: 4] = (dg >= 4'd5) ? (dg + 4'd3) : dg;
      end
   end

   // Sequencer: next state, datapath and output register loads
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      bits_in      = bits_ff;
      dig_in       = dig_ff;
      neg_in       = neg_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               neg_in   = raw_value[VALUE_WIDTH-1];
               mag_in   = raw_value[VALUE_WIDTH-1] ? (~raw_value + 1'b1) : raw_value;
               bcd_in   = '0;
               bits_in  = CNT_W'(VALUE_WIDTH);
               dig_in   = DIG_W'(ND);
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // one magnitude bit enters the BCD register per cycle
            bcd_in  = {bcd_adj[BW-2:0], mag_ff[VALUE_WIDTH-1]};
            mag_in  = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            bits_in = bits_ff - 1'b1;
            if (bits_ff == CNT_W'(1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zero digits, keep at least one
            if (top_digit == 4'd0 && dig_ff != DIG_W'(1)) begin
               bcd_in = {bcd_ff[BW-5:0], 4'd0};
               dig_in = dig_ff - 1'b1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_ZERO + {4'd0, top_digit};
               rsp_last_in  = (dig_ff == DIG_W'(1));
               bcd_in       = {bcd_ff[BW-5:0], 4'd0};
               dig_in       = dig_ff - 1'b1;
               if (dig_ff == DIG_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Output valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and output payload
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      bits_ff     <= bits_in;
      dig_ff      <= dig_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Checks
   `ASSERT_CLK(a_accept_starts, clock, reset, (req_tvalid && req_tready) |=> (state_ff == ST_CONVERT), "accepted request did not start conversion")
   `ASSERT_CLK(a_char_legal, clock, reset, rsp_tvalid |-> ((rsp_tdata == CHAR_MINUS) || ((rsp_tdata >= CHAR_ZERO) && (rsp_tdata <= CHAR_NINE))), "illegal output character")
   `ASSERT_CLK(a_sign_not_last, clock, reset, (rsp_tvalid && rsp_tdata == CHAR_MINUS) |-> !rsp_tlast, "sign marked as last character")
   `ASSERT_CLK(a_digits_left, clock, reset, (state_ff != ST_IDLE && state_ff != ST_CONVERT) |-> (dig_ff != '0), "digit counter ran out while busy")
   `ASSERT_ALWAYS(a_reset_clear, clock, reset |=> (!rsp_tvalid && state_ff == ST_IDLE), "reset did not clear control state")

endmodule

FILE: test/tb_signed_int_to_decimal_ascii.sv
// Testbench: signed integer to decimal text converter, checked beat by beat against a predictor.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;
   import sitda_pkg::*;

   localparam int VW        = VALUE_WIDTH_DEF;
   localparam int TDATA_W   = ((VW + 7) / 8) * 8;
   localparam int HOLD_LEN  = 300;
   localparam int HOLD_AT   = 28;
   localparam int STALL_MAX = 2000;
   localparam int TAIL_LEN  = 60;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } text_beat_type;

   // Predicts the character run of each value and checks the returned characters
   class decimal_text_board;
      text_beat_type pending[$];
      int            mismatches;
      int            values_seen;
      int            chars_checked;

      function new();
         mismatches    = 0;
         values_seen   = 0;
         chars_checked = 0;
      endfunction

      // Work out the expected text of one accepted value
      function void note_value(logic [VW-1:0] value);
         logic          negative;
         logic [VW-1:0] mag;
         logic [7:0]    digits[$];
         text_beat_type beat;
         negative = value[VW-1];
         // magnitude stays exact for the most negative value when kept unsigned
         mag = negative ? (~value + 1'b1) : value;
         do begin
            digits.push_front(CHAR_ZERO + 8'(mag % 10));
            mag = mag / 10;
         end while (mag != 0);
         if (negative) begin
            beat.ch   = CHAR_MINUS;
            beat.last = 1'b0;
            pending.push_back(beat);
         end
         foreach (digits[i]) begin
            beat.ch   = digits[i];
            beat.last = (i == digits.size() - 1);
            pending.push_back(beat);
         end
         values_seen++;
      endfunction

      // Compare one returned character with the oldest expectation
      function void check_char(logic [7:0] ch, logic last);
         text_beat_type want;
         chars_checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected character %h last %b with nothing pending", ch, last);
            return;
         end
         want = pending.pop_front();
         if (want.ch !== ch || want.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected char %h last %b, got char %h last %b",
                        want.ch, want.last, ch, last);
         end
      endfunction
   endclass

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [7:0]         rsp_tdata;
   logic               rsp_tlast;

   decimal_text_board board;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                hold_count    = 0;
   logic              hold_done     = 1'b0;
   int                quiet_cycles  = 0;

   always #5 clock = ~clock;

   signed_int_to_decimal_ascii #(.VALUE_WIDTH(VW)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Long receiver hold-off: started once after the first random values, counted down here
   always @(posedge clock) begin
      if (hold_count != 0) begin
         hold_count <= hold_count - 1;
      end else if (!reset && !hold_done && board.values_seen >= HOLD_AT) begin
         hold_count <= HOLD_LEN;
         hold_done  <= 1'b1;
      end
   end

   // Receiver: check accepted characters, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_char(rsp_tdata, rsp_tlast);
      rsp_tready <= !reset && (hold_count == 0) && ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one value, idling first at the sender rate; valid stays high into the next request unless that one idles
   task automatic send_value(input logic [VW-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'(value);
      do @(posedge clock); while (!req_tready);
      board.note_value(value);
   endtask

   // Stop offering and wait until every expected character has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0)
         @(posedge clock);
   endtask

   // Random value: mostly a random digit count and sign, some raw words and extremes
   function automatic logic [VW-1:0] random_value();
      int unsigned   n_digits;
      longint        lo;
      longint        hi;
      logic [VW-1:0] v;
      case ($urandom_range(9))
         0: v = $urandom;
         1: begin
            case ($urandom_range(4))
               0: v = 32'h8000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'hFFFF_FFFF;
               3: v = 32'h8000_0001;
               default: v = '0;
            endcase
         end
         default: begin
            n_digits = $urandom_range(10, 1);
            hi = 1;
            repeat (n_digits) hi = hi * 10;
            lo = (n_digits == 1) ? 0 : hi / 10;
            hi = hi - 1;
            if (hi > 64'd2147483647)
               hi = 64'd2147483647;
            v = $urandom_range(int'(hi), int'(lo));
            if ($urandom_range(1))
               v = -v;
         end
      endcase
      return v;
   endfunction

   initial begin
      logic [VW-1:0] directed[$];
      board = new();
      directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                   32'd999999999, -32'sd999999999, 32'd123456789, 32'h5555_5555,
                   32'hAAAA_AAAA, -32'sd1000000000};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Phase one: sender idles a third of the time, receiver two thirds
      send_idle_pct = 34;
      recv_idle_pct <= 65;
      foreach (directed[i])
         send_value(directed[i]);
      for (int i = 0; i < 50; i++)
         send_value(random_value());
      wait_drained();

      // Phase two: the rates swapped
      send_idle_pct = 65;
      recv_idle_pct <= 34;
      for (int i = 0; i < 55; i++)
         send_value(random_value());
      wait_drained();

      // Phase three: both sides at full rate
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      for (int i = 0; i < 55; i++)
         send_value(random_value());
      wait_drained();
      repeat (TAIL_LEN) @(posedge clock);

      $display("Converted %0d values into %0d characters under three stall mixes",
               board.values_seen, board.chars_checked);
      $display("and one long receiver hold; %0d mismatches, %0d characters left pending.",
               board.mismatches, board.pending.size());
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
